// ----- hdl/vspd_pkg.sv -----
// package for the vector stream plot decoder
// widths, command bytes, register indexes, job and config types
// no dependencies
package vspd_pkg;

  localparam int BYTE_W      = 8;
  localparam int COORD_W     = 16;
  localparam int ZOOM_W      = 5;
  localparam int PROD_W      = COORD_W + ZOOM_W;
  localparam int POS_W       = 22;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_STEPS   = PROD_W;
  localparam int CNT_W       = $clog2(DIV_STEPS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CMD_POINT  = 8'h1C;
  localparam logic [BYTE_W-1:0] CMD_VECTOR = 8'h1D;

  typedef enum logic [1:0] {
    REG_ZOOM          = 2'd0,
    REG_SCALE_DIVISOR = 2'd1,
    REG_OFFSET_H      = 2'd2,
    REG_OFFSET_V      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    JOB_VECTOR = 2'd0,
    JOB_POINT  = 2'd1,
    JOB_DARK   = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
  } job_t;

  typedef struct packed {
    logic [ZOOM_W-1:0]         zoom;
    logic [ZOOM_W-1:0]         scale_divisor;
    logic signed [COORD_W-1:0] offset_horizontal;
    logic signed [COORD_W-1:0] offset_vertical;
  } cfg_t;

endpackage

// ----- hdl/vspd_if.sv -----
// channel interfaces: command byte stream, draw requests, register writes
// depends on vspd_pkg
interface vspd_byte_if import vspd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface vspd_draw_if import vspd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    draw_kind;
  logic signed [POS_W-1:0] start_x;
  logic signed [POS_W-1:0] start_y;
  logic signed [POS_W-1:0] end_x;
  logic signed [POS_W-1:0] end_y;
  modport source (output valid, output draw_kind, output start_x, output start_y,
                  output end_x, output end_y, input ready);
  modport sink (input valid, input draw_kind, input start_x, input start_y,
                input end_x, input end_y, output ready);
endinterface

interface vspd_cfg_if import vspd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/vspd_front.sv -----
// front end: byte parser, mode tracking, coordinate assembly
// depends on vspd_pkg and vspd_if; pushes one job per finished coordinate
module vspd_front import vspd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  vspd_byte_if.sink        stream,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);

  typedef enum logic [3:0] {
    PH_Y_HIGH = 4'b0001,
    PH_Y_LOW  = 4'b0010,
    PH_X_HIGH = 4'b0100,
    PH_X_LOW  = 4'b1000
  } phase_t;

  phase_t             phase;
  logic               point_mode;
  logic               dark_pending;
  logic [COORD_W-1:0] raw_y;
  logic [BYTE_W-1:0]  raw_x_high;
  logic               accept;

  assign stream.ready = (phase != PH_X_LOW) || job_ready;
  assign accept       = stream.valid && stream.ready;
  assign job_valid    = stream.valid && (phase == PH_X_LOW);

  always_comb begin
    job.raw_x = {raw_x_high, stream.stream_byte};
    job.raw_y = raw_y;
    if (point_mode) begin
      job.kind = JOB_POINT;
    end else if (dark_pending) begin
      job.kind = JOB_DARK;
    end else begin
      job.kind = JOB_VECTOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_Y_HIGH;
      point_mode   <= 1'b0;
      dark_pending <= 1'b1;
      raw_y        <= '0;
      raw_x_high   <= '0;
    end else if (accept) begin
      case (phase)
        PH_Y_HIGH: begin
          if (stream.stream_byte == CMD_VECTOR) begin
            if (!point_mode) begin
              dark_pending <= 1'b1;
            end
            point_mode <= 1'b0;
          end else if (stream.stream_byte == CMD_POINT) begin
            point_mode <= 1'b1;
          end else begin
            raw_y[COORD_W-1:BYTE_W] <= stream.stream_byte;
            phase                   <= PH_Y_LOW;
          end
        end
        PH_Y_LOW: begin
          raw_y[BYTE_W-1:0] <= stream.stream_byte;
          phase             <= PH_X_HIGH;
        end
        PH_X_HIGH: begin
          raw_x_high <= stream.stream_byte;
          phase      <= PH_X_LOW;
        end
        PH_X_LOW: begin
          // dark move consumed here, points leave it alone
          if (!point_mode) begin
            dark_pending <= 1'b0;
          end
          phase <= PH_Y_HIGH;
        end
        default: begin
          phase <= PH_Y_HIGH;
        end
      endcase
    end
  end

  a_last_byte_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_X_LOW) |-> (job_valid && job_ready))
    else $error("final coordinate byte taken without a job push");

  a_dark_cleared_after_vector: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_X_LOW && !point_mode) |=> !dark_pending)
    else $error("dark move still pending after a vector coordinate");

endmodule

// ----- hdl/vspd_queue.sv -----
// two-entry job queue between front and back
// depends on vspd_pkg
module vspd_queue import vspd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/vspd_back.sv -----
// back end: zoom multiply, restoring divide, offset add, draw request register
// depends on vspd_pkg and vspd_if; keeps the last scaled position
module vspd_back import vspd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  vspd_draw_if.source draw
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic [ZOOM_W-1:0] rem;
    logic [PROD_W-1:0] dvd;
  } div_t;

  state_t                  state;
  job_kind_t               kind;
  div_t                    div_x;
  div_t                    div_y;
  logic [CNT_W-1:0]        count;
  logic signed [POS_W-1:0] last_x;
  logic signed [POS_W-1:0] last_y;
  logic [ZOOM_W-1:0]       divisor;
  div_t                    div_x_next;
  div_t                    div_y_next;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    out_free;
  logic                    load_out;

  // one restoring step: quotient bit shifts into the dividend's low end
  function automatic div_t div_step(div_t cur, logic [ZOOM_W-1:0] d);
    logic [ZOOM_W:0] trial;
    div_t            res;
    trial = {cur.rem, cur.dvd[PROD_W-1]};
    if (trial >= {1'b0, d}) begin
      res.rem = ZOOM_W'(trial - {1'b0, d});
      res.dvd = {cur.dvd[PROD_W-2:0], 1'b1};
    end else begin
      res.rem = trial[ZOOM_W-1:0];
      res.dvd = {cur.dvd[PROD_W-2:0], 1'b0};
    end
    return res;
  endfunction

  assign divisor    = (cfg.scale_divisor == '0) ? ZOOM_W'(1) : cfg.scale_divisor;
  assign div_x_next = div_step(div_x, divisor);
  assign div_y_next = div_step(div_y, divisor);
  assign pos_x      = POS_W'(signed'({1'b0, div_x.dvd})) + POS_W'(cfg.offset_horizontal);
  assign pos_y      = POS_W'(signed'({1'b0, div_y.dvd})) + POS_W'(cfg.offset_vertical);
  assign job_ready  = (state == S_IDLE);
  assign out_free   = !draw.valid || draw.ready;
  assign load_out   = (state == S_EMIT) && (kind != JOB_DARK) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      last_x <= '0;
      last_y <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_DIV;
            count <= '0;
          end
        end
        S_DIV: begin
          count <= count + 1'b1;
          if (count == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (kind == JOB_DARK || out_free) begin
            last_x <= pos_x;
            last_y <= pos_y;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      kind      <= job.kind;
      div_x.rem <= '0;
      div_y.rem <= '0;
      div_x.dvd <= PROD_W'(job.raw_x) * PROD_W'(cfg.zoom);
      div_y.dvd <= PROD_W'(job.raw_y) * PROD_W'(cfg.zoom);
    end else if (state == S_DIV) begin
      div_x <= div_x_next;
      div_y <= div_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw.valid <= 1'b0;
    end else if (load_out) begin
      draw.valid <= 1'b1;
    end else if (draw.ready) begin
      draw.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      draw.end_x <= pos_x;
      draw.end_y <= pos_y;
      if (kind == JOB_POINT) begin
        draw.draw_kind <= 1'b1;
        draw.start_x   <= '0;
        draw.start_y   <= '0;
      end else begin
        draw.draw_kind <= 1'b0;
        draw.start_x   <= last_x;
        draw.start_y   <= last_y;
      end
    end
  end

  a_pop_starts_divide: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job_ready) |=> (state == S_DIV && count == '0))
    else $error("job taken without starting the divider");

  a_request_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(draw.valid) |-> $past(state == S_EMIT))
    else $error("draw request raised outside the emit step");

  a_divide_complete: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (count == CNT_W'(DIV_STEPS)))
    else $error("emit reached before all quotient bits were formed");

endmodule

// ----- hdl/vector_stream_plot_decoder_unit.sv -----
// top level of the vector stream plot decoder
// depends on vspd_pkg, vspd_if, vspd_front, vspd_queue, vspd_back
//
// channel  role    payload                                  request
// stream   sink    stream_byte[7:0]                         one command byte
// draw     source  draw_kind, start_x/y, end_x/y [21:0]     one vector or point
// cfg      sink    index[1:0], data[15:0]                   one register write
//
// flow: bytes are taken one a cycle, the last byte of a coordinate only while the
//   two-entry job queue has room for it; the back end takes each coordinate through
//   a multiply, 21 restoring divide steps of one quotient bit each and an emit,
//   and pops the next coordinate from the queue only once the emit is done
// reset: rst is synchronous; registers return to zoom 1, divisor 1, offsets 0,
//   vector mode with a dark move pending and last position at the origin
// stalls: a held draw request stops the back end at its emit step, the queue
//   then fills and only the last byte of a coordinate is held off
// cfg is always ready; writes are meant for when the block is idle
module vector_stream_plot_decoder_unit import vspd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  vspd_byte_if.sink   stream,
  vspd_draw_if.source draw,
  vspd_cfg_if.sink    cfg
);

  // configuration registers, written from the cfg channel
  cfg_t cfg_regs;

  // front to queue
  logic push_valid;
  logic push_ready;
  job_t push_job;

  // queue to back
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // register writes never stall
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.zoom              <= ZOOM_W'(1);
      cfg_regs.scale_divisor     <= ZOOM_W'(1);
      cfg_regs.offset_horizontal <= '0;
      cfg_regs.offset_vertical   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ZOOM: begin
          cfg_regs.zoom <= cfg.data[ZOOM_W-1:0];
        end
        REG_SCALE_DIVISOR: begin
          cfg_regs.scale_divisor <= cfg.data[ZOOM_W-1:0];
        end
        REG_OFFSET_H: begin
          cfg_regs.offset_horizontal <= signed'(cfg.data[COORD_W-1:0]);
        end
        REG_OFFSET_V: begin
          cfg_regs.offset_vertical <= signed'(cfg.data[COORD_W-1:0]);
        end
        default: begin
          cfg_regs <= cfg_regs;
        end
      endcase
    end
  end

  // byte parser: mode bytes, coordinate assembly, dark move marking
  vspd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  // decouples parsing from the slow scaling path
  vspd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // scaling, last position tracking and the draw request register
  vspd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .draw      (draw)
  );

endmodule
